// ===== src/gc44_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gc44_pkg
// Shared constants, types and helpers of the 4x4 gradient classifier.
// ----------------------------------------------------------------------------
package gc44_pkg;

    localparam int MAX_COLS   = 256;
    localparam int PREC       = 16;
    localparam int PIX_W      = 16;
    localparam int COL_W      = $clog2(MAX_COLS);
    localparam int ROW_W      = 11;
    localparam int NUM_KINDS  = 4;

    localparam logic [1:0] REG_COLS  = 2'd0;
    localparam logic [1:0] REG_ROWS  = 2'd1;
    localparam logic [1:0] REG_DEPTH = 2'd2;

    typedef logic [PIX_W-1:0] pix_t;

    typedef struct packed {
        logic             valid;
        logic             odd_line;
        logic             emit_ok;
        logic             emit;
        logic             last;
        logic [8:0]       brow;
        logic [6:0]       bcol;
        logic [COL_W-1:0] col;
    } ctl_t;

    function automatic pix_t lap16(input pix_t m, input pix_t a, input pix_t b);
        logic [PIX_W-1:0] d;
        begin
            d = {m[PIX_W-2:0], 1'b0} - a - b;
            lap16 = d[PIX_W-1] ? (~d + 16'd1) : d;
        end
    endfunction

endpackage

// ===== src/gc44_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gc44_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module gc44_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== src/gc44_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gc44_cell
// One Laplacian lane: pair sum over two lines, four-line column sum through
// stores, then a three-deep column window giving the 4x4 sum.
// ----------------------------------------------------------------------------
module gc44_cell
    import gc44_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       restart,
    input  logic       hold,
    input  ctl_t       ctl,
    input  pix_t       lap,
    input  pix_t       mask,
    output pix_t       grad
);

    pix_t first_rd, prev_rd, pair, col4;
    pix_t cw0_reg, cw1_reg, cw2_reg;
    pix_t lap_reg;
    ctl_t ctl_reg;

    // reads are issued ahead of use through the registered RAM read: addresses come straight from ctl
    gc44_ram #(.WIDTH(PIX_W), .DEPTH(MAX_COLS)) u_first (
        .clk(clk), .we(ctl.valid && !ctl.odd_line), .waddr(ctl.col), .wdata(lap),
        .re(ctl.valid), .raddr(ctl.col), .rdata(first_rd));

    gc44_ram #(.WIDTH(PIX_W), .DEPTH(MAX_COLS)) u_prev (
        .clk(clk), .we(ctl_reg.valid && ctl_reg.odd_line && !hold), .waddr(ctl_reg.col),
        .wdata(pair), .re(ctl.valid), .raddr(ctl.col), .rdata(prev_rd));

    assign pair = first_rd + lap_reg;
    assign col4 = prev_rd + pair;

    // hold the lane while the output word waits
    always_ff @(posedge clk)
    begin
        if (!hold)
        begin
            lap_reg <= lap;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
            cw0_reg <= '0;
            cw1_reg <= '0;
            cw2_reg <= '0;
            grad    <= '0;
        end
        else if (!hold)
        begin
            ctl_reg <= restart ? '0 : ctl;
            if (ctl_reg.valid && ctl_reg.odd_line && ctl_reg.emit_ok)
            begin
                grad    <= (cw0_reg + cw1_reg + cw2_reg + col4) & mask;
                cw0_reg <= cw1_reg;
                cw1_reg <= cw2_reg;
                cw2_reg <= col4;
            end
        end
    end

endmodule

// ===== src/gradient_class_4x4.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gradient_class_4x4
// 4x4 gradient sums and 2x2 block classes over a padded pixel region.
// A block word passes the input register, the pixel window, the lane registers and the output register.
// Throughput: one pixel a cycle; the input stalls only while the receiver
// holds a block word, and the whole pipe freezes with it.
// Reset clears counters, windows and registers to 64x64 at depth 10; the
// line stores need no clearing.
// ----------------------------------------------------------------------------
module gradient_class_4x4
    import gc44_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] pixel,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] grad_vertical,
    output logic [15:0] grad_horizontal,
    output logic [15:0] grad_diag_down,
    output logic [15:0] grad_diag_up,
    output logic [1:0]  block_class,
    output logic [8:0]  block_row,
    output logic [6:0]  block_col,
    output logic        last_block,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    logic [7:0]       cols_reg;
    logic [ROW_W-1:0] rows_reg;
    logic [4:0]       depth_reg;
    logic [COL_W-1:0] col_reg;
    logic [ROW_W-1:0] row_reg;
    logic             cfg_wr, adv, restart;
    logic [COL_W-1:0] w_eff;
    logic [ROW_W-1:0] h_full;
    pix_t             up2, up1, mask;
    pix_t             win_reg [3][3];
    logic             s1_valid_reg, s1_line_reg, s1_ok_reg, s1_emit_reg, s1_last_reg;
    logic [COL_W-1:0] s1_col_reg;
    logic [8:0]       s1_brow_reg;
    logic [6:0]       s1_bcol_reg;
    logic             s0_valid_reg;
    logic [COL_W-1:0] s0_col_reg;
    logic [ROW_W-1:0] s0_row_reg;
    logic             s0_last_reg;
    pix_t             s0_pix_reg;
    ctl_t             ctl, ctl_d_reg;
    pix_t             lap [NUM_KINDS];
    pix_t             grad [NUM_KINDS];
    logic             stall_any;
    logic [4:0]       dmin;

    // the whole pipe freezes while the output word is held
    assign stall_any = out_valid && out_stall;
    assign in_stall  = stall_any;
    assign cfg_ready = !stall_any;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign adv       = in_valid && !in_stall;
    assign restart   = cfg_wr && (cfg_index == REG_COLS || cfg_index == REG_ROWS
                       || cfg_index == REG_DEPTH);

    always_comb
    begin
        logic [7:0] c;
        logic [ROW_W-1:0] r;
        c = (cols_reg > 8'(MAX_COLS - 4)) ? 8'(MAX_COLS - 4) : cols_reg;
        c[0] = 1'b0;
        if (c < 8'd2) c = 8'd2;
        r = rows_reg;
        r[0] = 1'b0;
        if (r > 11'd1024) r = 11'd1024;
        if (r < 11'd2) r = 11'd2;
        w_eff  = COL_W'(c) + COL_W'(4);
        h_full = r + 11'd3;
        dmin   = (depth_reg < 5'(PREC)) ? depth_reg : 5'(PREC);
    end

    assign mask = 16'((17'd1 << (5'd16 - (5'(PREC) - dmin))) - 17'd1);

    // two padded lines of pixels, read at the current column and written at the previous pixel's column
    logic [COL_W-1:0] lrd_col;
    assign lrd_col = col_reg;

    gc44_ram #(.WIDTH(PIX_W), .DEPTH(MAX_COLS)) u_line0 (
        .clk(clk), .we(s0_valid_reg && !stall_any), .waddr(s0_col_reg), .wdata(up1),
        .re(adv), .raddr(lrd_col), .rdata(up2));
    gc44_ram #(.WIDTH(PIX_W), .DEPTH(MAX_COLS)) u_line1 (
        .clk(clk), .we(s0_valid_reg && !stall_any), .waddr(s0_col_reg), .wdata(s0_pix_reg),
        .re(adv), .raddr(lrd_col), .rdata(up1));

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_pix_reg <= pixel;
        end
    end

    // position counters; a column read in the same cycle as its write sees
    // old data, which is fine since each column recurs only once per line
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg     <= 8'd64;
            rows_reg     <= 11'd64;
            depth_reg    <= 5'd10;
            col_reg      <= '0;
            row_reg      <= '0;
            s0_valid_reg <= 1'b0;
            s0_col_reg   <= '0;
            s0_row_reg   <= '0;
            s0_last_reg  <= 1'b0;
        end
        else if (!stall_any)
        begin
            s0_valid_reg <= adv;
            if (cfg_wr)
            begin
                case (cfg_index)
                    REG_COLS:  cols_reg  <= cfg_data[7:0];
                    REG_ROWS:  rows_reg  <= cfg_data[ROW_W-1:0];
                    REG_DEPTH: depth_reg <= cfg_data[4:0];
                    default:   ;
                endcase
            end
            if (restart)
            begin
                col_reg <= '0;
                row_reg <= '0;
            end
            else if (adv)
            begin
                s0_col_reg  <= col_reg;
                s0_row_reg  <= row_reg;
                s0_last_reg <= (row_reg == h_full && col_reg == w_eff - COL_W'(1));
                if (col_reg == w_eff - COL_W'(1))
                begin
                    col_reg <= '0;
                    row_reg <= (row_reg == h_full) ? '0 : row_reg + 11'd1;
                end
                else
                begin
                    col_reg <= col_reg + COL_W'(1);
                end
            end
        end
    end

    // 3x3 pixel window and Laplacian stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    win_reg[i][j] <= '0;
            s1_valid_reg <= 1'b0;
            s1_line_reg  <= 1'b0;
            s1_ok_reg    <= 1'b0;
            s1_emit_reg  <= 1'b0;
            s1_last_reg  <= 1'b0;
            s1_col_reg   <= '0;
            s1_brow_reg  <= '0;
            s1_bcol_reg  <= '0;
        end
        else if (!stall_any)
        begin
            s1_valid_reg <= s0_valid_reg && !restart && (s0_row_reg >= 11'd2)
                            && (s0_col_reg >= COL_W'(2));
            if (s0_valid_reg)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    win_reg[i][0] <= win_reg[i][1];
                    win_reg[i][1] <= win_reg[i][2];
                end
                win_reg[0][2] <= up2;
                win_reg[1][2] <= up1;
                win_reg[2][2] <= s0_pix_reg;
                s1_line_reg  <= s0_row_reg[0] ^ 1'b0;
                s1_ok_reg    <= s0_row_reg >= 11'd5;
                s1_emit_reg  <= (s0_col_reg >= COL_W'(5)) && s0_col_reg[0];
                s1_last_reg  <= s0_last_reg;
                s1_col_reg   <= s0_col_reg;
                s1_brow_reg  <= 9'((s0_row_reg - 11'd5) >> 1);
                s1_bcol_reg  <= 7'((s0_col_reg - COL_W'(5)) >> 1);
            end
        end
    end

    pix_t m;
    assign m      = win_reg[1][1];
    assign lap[0] = lap16(m, win_reg[0][1], win_reg[2][1]);
    assign lap[1] = lap16(m, win_reg[1][0], win_reg[1][2]);
    assign lap[2] = lap16(m, win_reg[0][0], win_reg[2][2]);
    assign lap[3] = lap16(m, win_reg[0][2], win_reg[2][0]);

    // line index p-2 is odd when p is odd
    always_comb
    begin
        ctl          = '0;
        ctl.valid    = s1_valid_reg && !stall_any;
        ctl.odd_line = s1_line_reg;
        ctl.emit_ok  = s1_ok_reg;
        ctl.emit     = s1_emit_reg;
        ctl.last     = s1_last_reg;
        ctl.brow     = s1_brow_reg;
        ctl.bcol     = s1_bcol_reg;
        ctl.col      = s1_col_reg;
    end

    genvar k;
    generate
        for (k = 0; k < NUM_KINDS; k++)
        begin : g_lane
            gc44_cell u_cell (
                .clk(clk), .rst_n(rst_n), .restart(restart), .hold(stall_any),
                .ctl(ctl), .lap(lap[k]), .mask(mask), .grad(grad[k]));
        end
    endgenerate

    // control follows the lanes: ctl_q_reg matches the cell input register, ctl_d_reg the lane sum
    ctl_t ctl_q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_q_reg       <= '0;
            ctl_d_reg       <= '0;
            out_valid       <= 1'b0;
            grad_vertical   <= '0;
            grad_horizontal <= '0;
            grad_diag_down  <= '0;
            grad_diag_up    <= '0;
            block_class     <= '0;
            block_row       <= '0;
            block_col       <= '0;
            last_block      <= 1'b0;
        end
        else if (!stall_any)
        begin
            ctl_q_reg <= restart ? '0 : ctl;
            ctl_d_reg <= ctl_q_reg.valid && ctl_q_reg.odd_line && ctl_q_reg.emit_ok
                         && ctl_q_reg.emit ? ctl_q_reg : '0;
            out_valid <= ctl_d_reg.valid;
            if (ctl_d_reg.valid)
            begin
                grad_vertical   <= grad[0];
                grad_horizontal <= grad[1];
                grad_diag_down  <= grad[2];
                grad_diag_up    <= grad[3];
                block_class     <= {grad[2] <= grad[3], grad[0] <= grad[1]};
                block_row       <= ctl_d_reg.brow;
                block_col       <= ctl_d_reg.bcol;
                last_block      <= ctl_d_reg.last;
            end
        end
    end

endmodule
